// File: hdl/mstp_pkg.sv
// Package with the item types, operation codes and controller interface types.
`default_nettype none
package mstp_pkg;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	localparam logic signed [3:0] PARENT_NONE = -4'sd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  src_vertex;
		logic [2:0]  dest_vertex;
		logic [15:0] edge_weight;
		logic [3:0]  vertex_count;
	} in_item_t;

	typedef struct packed {
		logic signed [3:0] parent_vertex;
		logic [2:0]        child_vertex;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic latch;
		logic cnt_zero;
		logic clr_step;
		logic add_write;
		logic run_init;
		logic scan_issue;
		logic round_next;
		logic out_start;
		logic out_issue;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       n_small;
		logic       cnt_last;
		logic       clr_last;
		logic       best_valid;
	} ctrl_sts_t;

endpackage
`default_nettype wire

// File: hdl/mstp_ctrl.sv
// Controller state machine sequencing clear, edge add and tree runs.
`default_nettype none
module mstp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output mstp_pkg::ctrl_cmd_t     cmd,
	input  wire mstp_pkg::ctrl_sts_t sts
);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DECODE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_RUN_INIT,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_DECIDE,
		ST_OUT,
		ST_OUT_WAIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					unique case (sts.op)
						mstp_pkg::OP_CLEAR: state_q <= ST_CLR;
						mstp_pkg::OP_ADD:   state_q <= ST_ADD_RD;
						mstp_pkg::OP_RUN:   state_q <= sts.n_small ? ST_IDLE : ST_RUN_INIT;
						default:            state_q <= ST_IDLE;
					endcase
				end
				ST_ADD_RD:    state_q <= ST_ADD_WR;
				ST_ADD_WR:    state_q <= ST_IDLE;
				ST_RUN_INIT:  state_q <= ST_SCAN;
				ST_SCAN: begin
					if (sts.cnt_last) state_q <= ST_SCAN_WAIT;
				end
				ST_SCAN_WAIT: state_q <= ST_DECIDE;
				ST_DECIDE:    state_q <= sts.best_valid ? ST_SCAN : ST_OUT;
				ST_OUT: begin
					if (sts.cnt_last) state_q <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT:  state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLR:      cmd.clr_step = 1'b1;
			ST_IDLE:     cmd.latch = start;
			ST_DECODE:   cmd.cnt_zero = (sts.op == mstp_pkg::OP_CLEAR);
			ST_ADD_WR:   cmd.add_write = 1'b1;
			ST_RUN_INIT: cmd.run_init = 1'b1;
			ST_SCAN:     cmd.scan_issue = 1'b1;
			ST_DECIDE: begin
				cmd.round_next = sts.best_valid;
				cmd.out_start  = !sts.best_valid;
			end
			ST_OUT:      cmd.out_issue = 1'b1;
			default:     cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/mstp_dp.sv
// Datapath with the weight memory, key and parent memories and the scan logic.
`default_nettype none
module mstp_dp #(
	parameter int MAX_VERTICES = 8,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mstp_pkg::in_item_t  item,
	input  wire mstp_pkg::ctrl_cmd_t cmd,
	output mstp_pkg::ctrl_sts_t      sts,
	output mstp_pkg::out_item_t      result,
	output logic                     result_valid
);

	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int CW    = $clog2(DEPTH);
	localparam int WB    = WEIGHT_BITS;

	logic [WB:0]    wmem [DEPTH];
	logic [WB-1:0]  key_mem [MAX_VERTICES];
	logic [VW-1:0]  parent_mem [MAX_VERTICES];

	logic [1:0]     op_q;
	logic [CW-1:0]  add_addr_q;
	logic           add_ok_q;
	logic [WB-1:0]  w_q;
	logic [NW-1:0]  n_q;
	logic [CW-1:0]  cnt_q;
	logic [VW-1:0]  u_q;
	logic [VW-1:0]  best_q;
	logic [WB-1:0]  best_key_q;
	logic           best_valid_q;
	logic [MAX_VERTICES-1:0] in_tree_q;
	logic [MAX_VERTICES-1:0] reached_q;
	logic [WB:0]    wrd_q;
	logic [WB-1:0]  key_rd_q;
	logic [VW-1:0]  par_rd_q;
	logic [VW-1:0]  v_s1;
	logic           scan_s1;
	logic           out_s1;

	logic [31:0]    src_ext;
	logic [31:0]    dst_ext;
	logic [31:0]    wt_ext;
	logic [31:0]    addr_ext;
	logic [VW-1:0]  cnt_idx;
	logic [CW-1:0]  n_m1;
	logic [CW-1:0]  scan_addr;
	logic [CW-1:0]  rd_addr;
	logic           wr_en;
	logic [CW-1:0]  wr_addr;
	logic [WB:0]    wr_data;
	logic           e_present;
	logic [WB-1:0]  e_wt;
	logic           notin;
	logic           rch;
	logic           upd;
	logic [WB-1:0]  new_key;
	logic           cand;
	logic [31:0]    par_ext;
	logic [31:0]    child_ext;

	assign src_ext  = 32'(item.src_vertex);
	assign dst_ext  = 32'(item.dest_vertex);
	assign wt_ext   = 32'(item.edge_weight);
	assign addr_ext = src_ext * 32'(MAX_VERTICES) + dst_ext;

	assign cnt_idx   = cnt_q[VW-1:0];
	assign n_m1      = CW'(n_q) - CW'(1);
	assign scan_addr = CW'(u_q) * CW'(MAX_VERTICES) + CW'(cnt_idx);
	assign rd_addr   = cmd.scan_issue ? scan_addr : add_addr_q;

	assign e_present = wrd_q[WB];
	assign e_wt      = wrd_q[WB-1:0];
	assign notin     = !in_tree_q[v_s1];
	assign rch       = reached_q[v_s1];
	assign upd       = scan_s1 && e_present && notin && (!rch || (e_wt < key_rd_q));
	assign new_key   = upd ? e_wt : key_rd_q;
	assign cand      = scan_s1 && notin && (rch || upd) &&
	                   (!best_valid_q || (new_key < best_key_q));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = add_addr_q;
		wr_data = {1'b1, w_q};
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
			wr_data = '0;
		end else if (cmd.add_write) begin
			wr_en = add_ok_q && (!e_present || (w_q < e_wt));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) wmem[wr_addr] <= wr_data;
		wrd_q <= wmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			key_mem[v_s1]    <= e_wt;
			parent_mem[v_s1] <= u_q;
		end
		key_rd_q <= key_mem[cnt_idx];
		par_rd_q <= parent_mem[cnt_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q       <= item.operation;
			add_addr_q <= addr_ext[CW-1:0];
			add_ok_q   <= (src_ext < 32'(MAX_VERTICES)) && (dst_ext < 32'(MAX_VERTICES));
			w_q        <= wt_ext[WB-1:0];
			n_q        <= (32'(item.vertex_count) > 32'(MAX_VERTICES)) ?
			              NW'(MAX_VERTICES) : NW'(item.vertex_count);
		end
		if (cmd.scan_issue || cmd.out_issue) v_s1 <= cnt_idx;
		if (cmd.run_init) begin
			u_q <= '0;
		end else if (cmd.round_next) begin
			u_q <= best_q;
		end
		if (cand) begin
			best_q     <= v_s1;
			best_key_q <= new_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			best_valid_q <= 1'b0;
			in_tree_q    <= '0;
			reached_q    <= '0;
			scan_s1      <= 1'b0;
			out_s1       <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_issue;
			out_s1  <= cmd.out_issue;
			if (cmd.cnt_zero || cmd.run_init || cmd.round_next) begin
				cnt_q <= '0;
			end else if (cmd.out_start) begin
				cnt_q <= CW'(1);
			end else if (cmd.clr_step || cmd.scan_issue || cmd.out_issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.run_init) begin
				in_tree_q    <= MAX_VERTICES'(1);
				reached_q    <= '0;
				best_valid_q <= 1'b0;
			end else if (cmd.round_next) begin
				in_tree_q[best_q] <= 1'b1;
				best_valid_q      <= 1'b0;
			end else begin
				if (upd) reached_q[v_s1] <= 1'b1;
				if (cand) best_valid_q <= 1'b1;
			end
		end
	end

	assign sts.op         = op_q;
	assign sts.n_small    = (n_q <= NW'(1));
	assign sts.cnt_last   = (cnt_q == n_m1);
	assign sts.clr_last   = (cnt_q == CW'(DEPTH - 1));
	assign sts.best_valid = best_valid_q;

	assign par_ext   = 32'(par_rd_q);
	assign child_ext = 32'(v_s1);

	always_comb begin
		result.parent_vertex = reached_q[v_s1] ? signed'(par_ext[3:0]) : mstp_pkg::PARENT_NONE;
		result.child_vertex  = child_ext[2:0];
		result.last          = (CW'(v_s1) == n_m1);
	end

	assign result_valid = out_s1;

endmodule
`default_nettype wire

// File: hdl/min_spanning_tree_prim_unit.sv
// Top level of the Prim minimum spanning tree unit.
// An item is taken when start is high and busy is low. After reset, and after every clear,
// the unit sweeps all MAX_VERTICES*MAX_VERTICES entries of the weight memory, one entry a cycle,
// with busy high. An edge add reads the stored entry and writes the new weight only where
// it is lower or no edge is stored. A run scans one row of the weight memory per tree vertex.
// Results leave on result with result_valid high for one cycle each, one per cycle, child 1
// to n-1 in order; the receiver cannot stall them, and every result has been shown by the
// time busy falls.
`default_nettype none
module min_spanning_tree_prim_unit #(
	parameter int MAX_VERTICES = 8,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire mstp_pkg::in_item_t item,
	output mstp_pkg::out_item_t     result,
	output logic                    result_valid
);

	mstp_pkg::ctrl_cmd_t cmd;
	mstp_pkg::ctrl_sts_t sts;

	mstp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	mstp_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the Prim minimum spanning tree unit: queued commands, tree prediction, checks.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV          = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 120;
	localparam logic [16:0] KEY_INF = 17'h10000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	mstp_pkg::in_item_t  item = '0;
	logic                busy;
	mstp_pkg::out_item_t result;
	logic                result_valid;

	mstp_pkg::in_item_t  pending_cmds[$];
	mstp_pkg::out_item_t expected_links[$];

	logic [15:0] weight_mem[NV*NV];
	bit          edge_valid[NV*NV];

	int gap_left = 0;
	int calm_left = 0;
	int error_count = 0;
	int cycle_count = 0;

	min_spanning_tree_prim_unit #(
		.MAX_VERTICES(NV),
		.WEIGHT_BITS (16)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result      (result),
		.result_valid(result_valid)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void queue_cmd(logic [1:0] op, logic [2:0] s, logic [2:0] d,
			logic [15:0] w, logic [3:0] c);
		mstp_pkg::in_item_t it;
		it.operation    = op;
		it.src_vertex   = s;
		it.dest_vertex  = d;
		it.edge_weight  = w;
		it.vertex_count = c;
		pending_cmds = {pending_cmds, it};
	endfunction

	function automatic void queue_noise_op(logic [1:0] op, logic [3:0] c);
		queue_cmd(op, 3'($urandom), 3'($urandom), 16'($urandom), c);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if (r < 3) begin
			calm_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// Updates the graph copy for one command and queues the tree links a run produces.
	function automatic void predict_tree_links(mstp_pkg::in_item_t it);
		int                  n;
		int                  u;
		int                  idx;
		logic [16:0]         key[NV];
		logic signed [3:0]   par[NV];
		bit                  done[NV];
		mstp_pkg::out_item_t link;
		case (it.operation)
			mstp_pkg::OP_CLEAR: begin
				foreach (edge_valid[i])
					edge_valid[i] = 1'b0;
			end
			mstp_pkg::OP_ADD: begin
				idx = int'({it.src_vertex, it.dest_vertex});
				if (!edge_valid[idx] || it.edge_weight < weight_mem[idx]) begin
					weight_mem[idx] = it.edge_weight;
					edge_valid[idx] = 1'b1;
				end
			end
			mstp_pkg::OP_RUN: begin
				n = (it.vertex_count > NV) ? NV : int'(it.vertex_count);
				if (n > 1) begin
					for (int v = 0; v < NV; v++) begin
						key[v]  = KEY_INF;
						par[v]  = mstp_pkg::PARENT_NONE;
						done[v] = 1'b0;
					end
					key[0] = '0;
					for (int r = 0; r < n; r++) begin
						u = -1;
						for (int v = 0; v < n; v++) begin
							if (!done[v] && key[v] < KEY_INF) begin
								if (u < 0)
									u = v;
								else if (key[v] < key[u])
									u = v;
							end
						end
						if (u < 0)
							break;
						done[u] = 1'b1;
						for (int v = 0; v < n; v++) begin
							idx = u * NV + v;
							if (edge_valid[idx] && !done[v] && key[v] > {1'b0, weight_mem[idx]}) begin
								key[v] = {1'b0, weight_mem[idx]};
								par[v] = 4'(u);
							end
						end
					end
					for (int v = 1; v < n; v++) begin
						link.parent_vertex = par[v];
						link.child_vertex  = 3'(v);
						link.last          = (v == n - 1);
						expected_links = {expected_links, link};
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			item     <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				predict_tree_links(item);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					start    <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_cmds.size() > 0) begin
					item     <= pending_cmds.pop_front();
					start    <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		mstp_pkg::out_item_t want;
		if (arst_n && result_valid) begin
			if (expected_links.size() == 0) begin
				$display("%0t: unexpected result parent=%0d child=%0d last=%0b", $time,
					result.parent_vertex, result.child_vertex, result.last);
				error_count++;
			end else begin
				want = expected_links.pop_front();
				if (result.parent_vertex !== want.parent_vertex) begin
					$display("%0t: parent_vertex of child %0d expected %0d actual %0d", $time,
						want.child_vertex, want.parent_vertex, result.parent_vertex);
					error_count++;
				end
				if (result.child_vertex !== want.child_vertex) begin
					$display("%0t: child_vertex expected %0d actual %0d", $time,
						want.child_vertex, result.child_vertex);
					error_count++;
				end
				if (result.last !== want.last) begin
					$display("%0t: last of child %0d expected %0b actual %0b", $time,
						want.child_vertex, want.last, result.last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d commands and %0d results outstanding", $time,
				pending_cmds.size(), expected_links.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int n_edges;
		bit narrow;
		int base;

		// Directed part: empty graph, min-weight replacement, ties, self loop, count limits.
		queue_cmd(mstp_pkg::OP_RUN, 3'd0, 3'd0, 16'd0, 4'd8);
		queue_cmd(mstp_pkg::OP_ADD, 3'd0, 3'd1, 16'hFFFF, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd0, 3'd1, 16'h0000, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd0, 3'd1, 16'h0007, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd1, 3'd2, 16'h0000, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd2, 3'd2, 16'h0001, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd2, 3'd3, 16'h8000, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd0, 3'd3, 16'h8000, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd7, 3'd6, 16'h0003, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd3, 3'd7, 16'h1234, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd0, 3'd5, 16'h1234, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd5, 3'd4, 16'hAAAA, 4'd0);
		queue_cmd(mstp_pkg::OP_ADD, 3'd6, 3'd4, 16'h5555, 4'd0);
		queue_cmd(mstp_pkg::OP_RUN, 3'd0, 3'd0, 16'd0, 4'd8);
		queue_cmd(mstp_pkg::OP_RUN, 3'd7, 3'd7, 16'hFFFF, 4'd15);
		queue_cmd(mstp_pkg::OP_RUN, 3'd0, 3'd0, 16'd0, 4'd4);
		queue_cmd(mstp_pkg::OP_RUN, 3'd0, 3'd0, 16'd0, 4'd1);
		queue_cmd(mstp_pkg::OP_RUN, 3'd0, 3'd0, 16'd0, 4'd0);
		queue_cmd(OP_UNUSED, 3'd7, 3'd7, 16'hFFFF, 4'd15);
		queue_cmd(mstp_pkg::OP_RUN, 3'd5, 3'd2, 16'h00FF, 4'd9);
		queue_cmd(mstp_pkg::OP_CLEAR, 3'd7, 3'd7, 16'hFFFF, 4'd15);
		queue_cmd(mstp_pkg::OP_RUN, 3'd0, 3'd0, 16'd0, 4'd8);
		queue_cmd(mstp_pkg::OP_ADD, 3'd1, 3'd0, 16'h0002, 4'd0);
		queue_cmd(mstp_pkg::OP_RUN, 3'd0, 3'd0, 16'd0, 4'd2);
		queue_cmd(mstp_pkg::OP_ADD, 3'd0, 3'd1, 16'hFFFF, 4'd0);

		// Random part: mostly graphs built and then solved, with some noise commands.
		base = pending_cmds.size();
		while (pending_cmds.size() - base < 200) begin
			if ($urandom_range(0, 1))
				queue_noise_op(mstp_pkg::OP_CLEAR, 4'($urandom));
			n_edges = $urandom_range(1, 16);
			narrow  = 1'($urandom_range(0, 1));
			for (int e = 0; e < n_edges; e++) begin
				if ($urandom_range(0, 19) == 0)
					queue_noise_op(OP_UNUSED, 4'($urandom));
				queue_cmd(mstp_pkg::OP_ADD, 3'($urandom), 3'($urandom),
					narrow ? 16'($urandom_range(0, 3)) : 16'($urandom), 4'($urandom));
			end
			if ($urandom_range(0, 4) != 0)
				queue_noise_op(mstp_pkg::OP_RUN, 4'($urandom_range(2, 8)));
			else
				queue_noise_op(mstp_pkg::OP_RUN, 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 5) == 0)
				queue_noise_op(mstp_pkg::OP_RUN, 4'($urandom_range(2, 8)));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_cmds.size() != 0 || start || busy || expected_links.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
